@@ hw/rtl/ctkd_pkg.sv @@
// Shared constants and types for the capacitive touch key detector.
// Used by the sorting cell, the averaging divider and the top level.
package ctkd_pkg;

    localparam int CAL_COUNT   = 10;
    localparam int SAMPLE_BITS = 16;
    localparam int FIELD_W     = 16;

    localparam int AVG_LO  = 2;
    localparam int AVG_HI  = CAL_COUNT - 3;
    localparam int AVG_DIV = CAL_COUNT - 4;

    localparam int FULL_SCALE = (2 ** SAMPLE_BITS) - 1;
    localparam int HALF_SCALE = FULL_SCALE / 2;

    localparam int SUM_W      = $clog2(AVG_DIV * FULL_SCALE + 1);
    localparam int CNT_W      = $clog2(CAL_COUNT + 1);

    // Four spare shift bits keep the reciprocal product exact for every sum.
    localparam int AVG_SHIFT = SUM_W + 4;
    localparam int AVG_RECIP = ((2 ** AVG_SHIFT) + AVG_DIV - 1) / AVG_DIV;
    localparam int RECIP_W   = $clog2(AVG_RECIP + 1);
    localparam int PROD_W    = SUM_W + RECIP_W;

    localparam int GROUP_W      = 4;
    localparam int GROUP_MAX    = 15;
    localparam int HOLD_W       = 3;
    localparam int HOLD_PRESS   = 5;
    localparam int HOLD_RELEASE = 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_MARGIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SAMPLES = 2'd2;

    localparam int GATE_MARGIN_RST    = 80;
    localparam int SINGLE_SAMPLES_RST = 3;
    localparam int REPEAT_SAMPLES_RST = 6;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic    valid;
        sample_t value;
    } link_t;

    typedef struct packed {
        logic drain;
        logic fill;
    } cell_ctl_t;

endpackage

@@ hw/rtl/capacitive_touch_key_detector_core.sv @@
// Capacitive touch key detector: calibration through a chain of sorting cells,
// then scan rounds that gate group maxima against baseline plus margin.
// Each calibration sample is sorted into the chain before the next is taken; after the
// last, the chain drains into the averaging sum, which is divided. A scan sample is
// taken every cycle while the skid stage is empty; a round result is registered and
// a skid stage holds a second one. Synchronous active-low reset clears control state.
module capacitive_touch_key_detector_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ctkd_pkg::FIELD_W-1:0]        s_charge_time,
    input  logic                                s_mode,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_result_kind,
    output logic                                m_pressed,
    output logic                                m_cal_fail,
    output logic [ctkd_pkg::FIELD_W-1:0]        m_baseline,
    output logic [ctkd_pkg::FIELD_W-1:0]        m_peak,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctkd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ctkd_pkg::FIELD_W-1:0]        cfg_data
);

    typedef enum logic [1:0] {
        S_CAL,
        S_DRAIN,
        S_DIV,
        S_SCAN
    } state_t;

    typedef struct packed {
        logic                         kind;
        logic                         pressed;
        logic                         cal_fail;
        logic [ctkd_pkg::FIELD_W-1:0] baseline;
        logic [ctkd_pkg::FIELD_W-1:0] peak;
    } result_t;

    state_t                                state_reg;
    logic [ctkd_pkg::CNT_W-1:0]            cal_count_reg;
    logic [ctkd_pkg::CNT_W-1:0]            drain_cnt_reg;
    logic [ctkd_pkg::SUM_W-1:0]            sum_reg;
    logic                                  div_start_reg;
    logic                                  tok_reg;
    ctkd_pkg::sample_t                     sample_reg;
    ctkd_pkg::sample_t                     baseline_reg;
    logic [ctkd_pkg::FIELD_W-1:0]          gate_margin_reg;
    logic [ctkd_pkg::GROUP_W-1:0]          single_reg;
    logic [ctkd_pkg::GROUP_W-1:0]          repeat_reg;
    logic [ctkd_pkg::HOLD_W-1:0]           hold_off_reg;
    logic                                  second_reg;
    logic [ctkd_pkg::GROUP_W-1:0]          group_count_reg;
    ctkd_pkg::sample_t                     group_max_reg;
    logic                                  round_repeat_reg;
    logic                                  m_valid_reg;
    logic                                  skid_valid_reg;
    result_t                               out_reg;
    result_t                               skid_reg;

    ctkd_pkg::link_t                       link_w [ctkd_pkg::CAL_COUNT+1];
    ctkd_pkg::sample_t                     held_w [ctkd_pkg::CAL_COUNT];
    ctkd_pkg::sample_t                     held_left [ctkd_pkg::CAL_COUNT];
    ctkd_pkg::cell_ctl_t                   ctl_w [ctkd_pkg::CAL_COUNT];
    logic [ctkd_pkg::CAL_COUNT:0]          link_valid;
    logic                                  chain_busy;

    logic                                  div_done;
    ctkd_pkg::sample_t                     div_quot;

    logic                                  s_xfer;
    logic                                  m_xfer;
    ctkd_pkg::sample_t                     sample;
    logic                                  round_start;
    logic                                  rr;
    logic [ctkd_pkg::HOLD_W-1:0]           ho;
    logic [ctkd_pkg::HOLD_W-1:0]           ho_rel;
    logic [ctkd_pkg::HOLD_W-1:0]           ho_release;
    ctkd_pkg::sample_t                     gm0;
    ctkd_pkg::sample_t                     gm;
    logic [ctkd_pkg::GROUP_W-1:0]          gc;
    logic [ctkd_pkg::GROUP_W-1:0]          len;
    logic                                  group_done;
    logic [ctkd_pkg::FIELD_W:0]            thr;
    logic                                  exceed;
    logic                                  in_avg;
    logic                                  push;
    result_t                               push_data;

    assign link_w[0].valid = tok_reg;
    assign link_w[0].value = sample_reg;
    assign held_left[0]    = '0;

    for (genvar i = 0; i < ctkd_pkg::CAL_COUNT; i++) begin : g_cell
        if (i > 0) begin : g_left
            assign held_left[i] = held_w[i-1];
        end
        assign ctl_w[i].drain = (state_reg == S_DRAIN);
        assign ctl_w[i].fill  = (cal_count_reg == ctkd_pkg::CNT_W'(i + 1));
        ctkd_sort_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl_w[i]),
            .pass_in  (link_w[i]),
            .held_in  (held_left[i]),
            .pass_out (link_w[i+1]),
            .held_out (held_w[i])
        );
    end

    for (genvar i = 0; i <= ctkd_pkg::CAL_COUNT; i++) begin : g_busy
        assign link_valid[i] = link_w[i].valid;
    end
    assign chain_busy = |link_valid;

    ctkd_avg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (sum_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb begin
        unique case (state_reg)
            S_CAL:   s_ready = (cal_count_reg != ctkd_pkg::CNT_W'(ctkd_pkg::CAL_COUNT))
                               && !chain_busy;
            S_SCAN:  s_ready = !skid_valid_reg;
            default: s_ready = 1'b0;
        endcase
    end

    assign s_xfer    = s_valid && s_ready;
    assign m_xfer    = m_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        sample      = s_charge_time[ctkd_pkg::SAMPLE_BITS-1:0];
        round_start = !second_reg && (group_count_reg == '0);
        rr          = round_start ? s_mode : round_repeat_reg;
        ho          = (round_start && s_mode) ? '0 : hold_off_reg;
        gm0         = round_start ? '0 : group_max_reg;
        gm          = (sample > gm0) ? sample : gm0;
        gc          = (group_count_reg != ctkd_pkg::GROUP_W'(ctkd_pkg::GROUP_MAX))
                      ? group_count_reg + 1'b1 : group_count_reg;
        len         = rr ? repeat_reg : single_reg;
        if (len == '0) begin
            len = ctkd_pkg::GROUP_W'(1);
        end
        group_done  = (gc >= len);
        thr         = (ctkd_pkg::FIELD_W + 1)'(baseline_reg)
                      + (ctkd_pkg::FIELD_W + 1)'(gate_margin_reg);
        exceed      = (ctkd_pkg::FIELD_W + 1)'(gm) > thr;
        ho_rel      = (ho > ctkd_pkg::HOLD_W'(ctkd_pkg::HOLD_RELEASE))
                      ? ctkd_pkg::HOLD_W'(ctkd_pkg::HOLD_RELEASE) : ho;
        ho_release  = (ho_rel != '0) ? ho_rel - 1'b1 : ho_rel;
        in_avg      = (drain_cnt_reg >= ctkd_pkg::CNT_W'(ctkd_pkg::AVG_LO))
                      && (drain_cnt_reg <= ctkd_pkg::CNT_W'(ctkd_pkg::AVG_HI));

        push      = 1'b0;
        push_data = '0;
        if (state_reg == S_DIV && div_done) begin
            push               = 1'b1;
            push_data.cal_fail = div_quot > ctkd_pkg::SAMPLE_BITS'(ctkd_pkg::HALF_SCALE);
            push_data.baseline = ctkd_pkg::FIELD_W'(div_quot);
        end else if (state_reg == S_SCAN && s_xfer && group_done
                     && (second_reg || !exceed)) begin
            push               = 1'b1;
            push_data.kind     = 1'b1;
            push_data.pressed  = second_reg && (ho == '0) && exceed;
            push_data.baseline = ctkd_pkg::FIELD_W'(baseline_reg);
            push_data.peak     = ctkd_pkg::FIELD_W'(gm);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CAL;
            cal_count_reg    <= '0;
            drain_cnt_reg    <= '0;
            div_start_reg    <= 1'b0;
            tok_reg          <= 1'b0;
            baseline_reg     <= '0;
            gate_margin_reg  <= ctkd_pkg::FIELD_W'(ctkd_pkg::GATE_MARGIN_RST);
            single_reg       <= ctkd_pkg::GROUP_W'(ctkd_pkg::SINGLE_SAMPLES_RST);
            repeat_reg       <= ctkd_pkg::GROUP_W'(ctkd_pkg::REPEAT_SAMPLES_RST);
            hold_off_reg     <= '0;
            second_reg       <= 1'b0;
            group_count_reg  <= '0;
            group_max_reg    <= '0;
            round_repeat_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            tok_reg       <= 1'b0;
            div_start_reg <= 1'b0;

            if (cfg_valid) begin
                unique case (cfg_index)
                    ctkd_pkg::CFG_GATE_MARGIN:    gate_margin_reg <= cfg_data;
                    ctkd_pkg::CFG_SINGLE_SAMPLES: single_reg <= cfg_data[ctkd_pkg::GROUP_W-1:0];
                    ctkd_pkg::CFG_REPEAT_SAMPLES: repeat_reg <= cfg_data[ctkd_pkg::GROUP_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_CAL: begin
                    if (s_xfer) begin
                        sample_reg    <= sample;
                        tok_reg       <= 1'b1;
                        cal_count_reg <= cal_count_reg + 1'b1;
                    end else if (!chain_busy &&
                                 cal_count_reg == ctkd_pkg::CNT_W'(ctkd_pkg::CAL_COUNT)) begin
                        state_reg     <= S_DRAIN;
                        drain_cnt_reg <= '0;
                        sum_reg       <= '0;
                    end
                end
                S_DRAIN: begin
                    if (in_avg) begin
                        sum_reg <= sum_reg + ctkd_pkg::SUM_W'(held_w[ctkd_pkg::CAL_COUNT-1]);
                    end
                    drain_cnt_reg <= drain_cnt_reg + 1'b1;
                    if (drain_cnt_reg == ctkd_pkg::CNT_W'(ctkd_pkg::AVG_HI)) begin
                        state_reg     <= S_DIV;
                        div_start_reg <= 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        baseline_reg <= div_quot;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (s_xfer) begin
                        round_repeat_reg <= rr;
                        if (!group_done) begin
                            hold_off_reg    <= ho;
                            group_max_reg   <= gm;
                            group_count_reg <= gc;
                        end else begin
                            group_count_reg <= '0;
                            group_max_reg   <= '0;
                            if (!second_reg && exceed) begin
                                second_reg   <= 1'b1;
                                hold_off_reg <= ho;
                            end else begin
                                second_reg   <= 1'b0;
                                hold_off_reg <= second_reg
                                                ? ctkd_pkg::HOLD_W'(ctkd_pkg::HOLD_PRESS - 1)
                                                : ho_release;
                            end
                        end
                    end
                end
                default: ;
            endcase

            if (skid_valid_reg) begin
                if (m_xfer) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (!m_valid_reg || m_xfer) begin
                    out_reg     <= push_data;
                    m_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= push_data;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_xfer) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = out_reg.kind;
    assign m_pressed     = out_reg.pressed;
    assign m_cal_fail    = out_reg.cal_fail;
    assign m_baseline    = out_reg.baseline;
    assign m_peak        = out_reg.peak;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("Skid stage holds a transfer while the output register is empty.");

    a_drain_chain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN) |-> !chain_busy)
        else $error("Sorting chain still moving a sample during drain.");

    a_hold_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_off_reg <= ctkd_pkg::HOLD_W'(ctkd_pkg::HOLD_PRESS - 1))
        else $error("Hold-off counter above its press value.");

    a_cal_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_done) |=> (m_valid_reg && !m_result_kind))
        else $error("Calibration result not presented after averaging.");

endmodule

@@ hw/rtl/ctkd_sort_cell.sv @@
// One cell of the calibration insertion-sort chain: keeps the smaller value
// and hands the larger one on; in fill mode keeps the incoming value; in
// drain mode takes its left neighbour's value. Depends on ctkd_pkg.
module ctkd_sort_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  ctkd_pkg::cell_ctl_t ctl,
    input  ctkd_pkg::link_t     pass_in,
    input  ctkd_pkg::sample_t   held_in,
    output ctkd_pkg::link_t     pass_out,
    output ctkd_pkg::sample_t   held_out
);

    ctkd_pkg::sample_t held_reg;
    ctkd_pkg::sample_t held_next;
    ctkd_pkg::sample_t pass_value_reg;
    ctkd_pkg::sample_t pass_value_next;
    logic              pass_valid_reg;
    logic              pass_valid_next;

    always_comb begin
        held_next       = held_reg;
        pass_value_next = pass_value_reg;
        pass_valid_next = 1'b0;
        if (ctl.drain) begin
            held_next = held_in;
        end else if (pass_in.valid) begin
            if (ctl.fill) begin
                held_next = pass_in.value;
            end else begin
                pass_valid_next = 1'b1;
                if (pass_in.value < held_reg) begin
                    held_next       = pass_in.value;
                    pass_value_next = held_reg;
                end else begin
                    pass_value_next = pass_in.value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_valid_reg <= 1'b0;
        end else begin
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_reg       <= held_next;
        pass_value_reg <= pass_value_next;
    end

    assign pass_out.valid = pass_valid_reg;
    assign pass_out.value = pass_value_reg;
    assign held_out       = held_reg;

endmodule

@@ hw/rtl/ctkd_avg_div.sv @@
// Division of the averaging sum by the fixed count through a registered
// multiplication by its reciprocal. Depends on ctkd_pkg.
module ctkd_avg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ctkd_pkg::SUM_W-1:0]    dividend,
    output logic                          done,
    output ctkd_pkg::sample_t             quotient
);

    logic [ctkd_pkg::PROD_W-1:0] prod_reg;
    logic [ctkd_pkg::PROD_W-1:0] prod_next;
    logic                        done_reg;

    always_comb begin
        prod_next = ctkd_pkg::PROD_W'(dividend)
                    * ctkd_pkg::PROD_W'(ctkd_pkg::AVG_RECIP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= prod_next;
        end
    end

    assign done     = done_reg;
    assign quotient = prod_reg[ctkd_pkg::AVG_SHIFT +: ctkd_pkg::SAMPLE_BITS];

endmodule

@@ bench/touch_key_checker.sv @@
// Checker for the capacitive touch key detector: watches the sample, result and
// register channels, predicts every result and compares it field by field.
// Depends on ctkd_pkg for widths, register indexes and reset values.
module touch_key_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [ctkd_pkg::FIELD_W-1:0]   s_charge_time,
    input  logic                           s_mode,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic                           m_result_kind,
    input  logic                           m_pressed,
    input  logic                           m_cal_fail,
    input  logic [ctkd_pkg::FIELD_W-1:0]   m_baseline,
    input  logic [ctkd_pkg::FIELD_W-1:0]   m_peak,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ctkd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ctkd_pkg::FIELD_W-1:0]   cfg_data,
    output int                             fail_count,
    output int                             pending,
    output int                             inputs_seen,
    output int                             rounds_seen,
    output int                             presses_seen
);
    import ctkd_pkg::*;

    typedef struct packed {
        logic    kind;
        logic    pressed;
        logic    cal_fail;
        sample_t baseline;
        sample_t peak;
    } touch_report_t;

    logic [FIELD_W-1:0] margin_reg;
    logic [GROUP_W-1:0] single_len;
    logic [GROUP_W-1:0] repeat_len;

    sample_t            cal_samples [CAL_COUNT];
    int                 cal_fill;
    sample_t            baseline_q;
    logic               calibrated;
    logic [HOLD_W-1:0]  hold_off;
    logic               in_second;
    logic [GROUP_W-1:0] group_fill;
    sample_t            group_peak;
    logic               round_repeat;

    touch_report_t      expected_reports [$];
    touch_report_t      want;
    int                 fails;
    int                 inputs_n;
    int                 rounds_n;
    int                 presses_n;

    function automatic void advance_detector(input sample_t sample, input logic mode);
        sample_t            sorted [CAL_COUNT];
        sample_t            key;
        int                 j;
        int unsigned        sum;
        logic [GROUP_W-1:0] len;
        logic [FIELD_W:0]   threshold;
        logic               over;
        touch_report_t      report;

        if (!calibrated) begin
            if (cal_fill < CAL_COUNT) begin
                cal_samples[cal_fill] = sample;
            end
            cal_fill++;
            if (cal_fill < CAL_COUNT) begin
                return;
            end
            sorted = cal_samples;
            for (int i = 1; i < CAL_COUNT; i++) begin
                key = sorted[i];
                j = i;
                while (j > 0 && sorted[j-1] > key) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = key;
            end
            sum = 0;
            for (int i = AVG_LO; i <= AVG_HI; i++) begin
                sum += sorted[i];
            end
            baseline_q = sample_t'(sum / AVG_DIV);
            calibrated = 1'b1;
            report.kind     = 1'b0;
            report.pressed  = 1'b0;
            report.cal_fail = (baseline_q > HALF_SCALE);
            report.baseline = baseline_q;
            report.peak     = '0;
            expected_reports.push_back(report);
            return;
        end

        // The first sample of a round fixes the mode; repeat mode also clears the hold-off.
        if (!in_second && group_fill == 0) begin
            round_repeat = mode;
            if (mode) begin
                hold_off = '0;
            end
            group_peak = '0;
        end
        if (sample > group_peak) begin
            group_peak = sample;
        end
        if (group_fill < GROUP_MAX) begin
            group_fill++;
        end

        len = round_repeat ? repeat_len : single_len;
        if (len == 0) begin
            len = GROUP_W'(1);
        end
        if (group_fill < len) begin
            return;
        end

        threshold = {1'b0, baseline_q} + {1'b0, margin_reg};
        over = ({1'b0, group_peak} > threshold);

        if (!in_second) begin
            if (over) begin
                in_second  = 1'b1;
                group_fill = '0;
                group_peak = '0;
                return;
            end
            if (hold_off > HOLD_RELEASE) begin
                hold_off = HOLD_W'(HOLD_RELEASE);
            end
            if (hold_off != 0) begin
                hold_off--;
            end
            report.pressed = 1'b0;
        end else begin
            report.pressed = (hold_off == 0) && over;
            hold_off = HOLD_W'(HOLD_PRESS - 1);
        end

        report.kind     = 1'b1;
        report.cal_fail = 1'b0;
        report.baseline = baseline_q;
        report.peak     = group_peak;
        expected_reports.push_back(report);
        in_second  = 1'b0;
        group_fill = '0;
        group_peak = '0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg   = FIELD_W'(GATE_MARGIN_RST);
            single_len   = GROUP_W'(SINGLE_SAMPLES_RST);
            repeat_len   = GROUP_W'(REPEAT_SAMPLES_RST);
            cal_fill     = 0;
            baseline_q   = '0;
            calibrated   = 1'b0;
            hold_off     = '0;
            in_second    = 1'b0;
            group_fill   = '0;
            group_peak   = '0;
            round_repeat = 1'b0;
            fails        = 0;
            inputs_n     = 0;
            rounds_n     = 0;
            presses_n    = 0;
            for (int i = 0; i < CAL_COUNT; i++) begin
                cal_samples[i] = '0;
            end
            expected_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_GATE_MARGIN:    margin_reg = cfg_data;
                    CFG_SINGLE_SAMPLES: single_len = cfg_data[GROUP_W-1:0];
                    CFG_REPEAT_SAMPLES: repeat_len = cfg_data[GROUP_W-1:0];
                    default: ;
                endcase
            end

            // A result can never stem from a sample accepted on the same edge,
            // so the result transfer is matched before the new sample is predicted.
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result transfer with nothing expected: kind %0d peak %0d",
                           m_result_kind, m_peak);
                    fails++;
                end else begin
                    want = expected_reports.pop_front();
                    if (m_result_kind !== want.kind) begin
                        $error("result_kind: expected %0d, got %0d", want.kind, m_result_kind);
                        fails++;
                    end
                    if (m_pressed !== want.pressed) begin
                        $error("pressed: expected %0d, got %0d", want.pressed, m_pressed);
                        fails++;
                    end
                    if (m_cal_fail !== want.cal_fail) begin
                        $error("cal_fail: expected %0d, got %0d", want.cal_fail, m_cal_fail);
                        fails++;
                    end
                    if (m_baseline !== want.baseline) begin
                        $error("baseline: expected %0d, got %0d", want.baseline, m_baseline);
                        fails++;
                    end
                    if (m_peak !== want.peak) begin
                        $error("peak: expected %0d, got %0d", want.peak, m_peak);
                        fails++;
                    end
                    if (want.kind) begin
                        rounds_n++;
                    end
                    if (want.pressed) begin
                        presses_n++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                inputs_n++;
                advance_detector(s_charge_time[SAMPLE_BITS-1:0], s_mode);
            end
        end
        fail_count   <= fails;
        pending      <= expected_reports.size();
        inputs_seen  <= inputs_n;
        rounds_seen  <= rounds_n;
        presses_seen <= presses_n;
    end

endmodule

@@ bench/tb.sv @@
// Top of the touch key detector bench: clock, reset, sample and register stimulus,
// random stalls on both channels and the final verdict.
// Depends on ctkd_pkg, the detector core and touch_key_checker.
module tb;
    import ctkd_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 216;
    localparam int IDLE_PERCENT    = 22;
    localparam int LONG_STALL      = 300;
    localparam int SETTLE_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [FIELD_W-1:0]   s_charge_time;
    logic                 s_mode;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_result_kind;
    logic                 m_pressed;
    logic                 m_cal_fail;
    logic [FIELD_W-1:0]   m_baseline;
    logic [FIELD_W-1:0]   m_peak;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FIELD_W-1:0]   cfg_data;

    int   fail_count;
    int   pending;
    int   inputs_seen;
    int   rounds_seen;
    int   presses_seen;
    int   quiet_cycles = 0;
    int   stall_asks = 0;
    int   stall_seen = 0;
    logic steady = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    capacitive_touch_key_detector_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_charge_time (s_charge_time),
        .s_mode        (s_mode),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_pressed     (m_pressed),
        .m_cal_fail    (m_cal_fail),
        .m_baseline    (m_baseline),
        .m_peak        (m_peak),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    touch_key_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_charge_time (s_charge_time),
        .s_mode        (s_mode),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_kind (m_result_kind),
        .m_pressed     (m_pressed),
        .m_cal_fail    (m_cal_fail),
        .m_baseline    (m_baseline),
        .m_peak        (m_peak),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .inputs_seen   (inputs_seen),
        .rounds_seen   (rounds_seen),
        .presses_seen  (presses_seen)
    );

    task automatic send_sample(input sample_t charge, input logic mode);
        int gap;
        gap = 0;
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                gap++;
            end
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_charge_time <= charge;
        s_mode        <= mode;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [FIELD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_seen != stall_asks) begin
                stall_seen = stall_asks;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
            end
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int unsigned        centre;
        int unsigned        spread_in;
        int unsigned        spread_out;
        int unsigned        threshold;
        int unsigned        floor_val;
        int unsigned        roll;
        sample_t            cal_set [CAL_COUNT];
        sample_t            swap;
        sample_t            charge;
        int                 k;
        int                 left;
        logic               touching;
        logic               episode_mode;
        logic               mode;
        logic [FIELD_W-1:0] pick_margin;
        logic [GROUP_W-1:0] pick_single;
        logic [GROUP_W-1:0] pick_repeat;

        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_charge_time = '0;
        s_mode        = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_GATE_MARGIN;
        cfg_data      = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Short groups for the directed part; the margin keeps its reset value.
        write_register(CFG_SINGLE_SAMPLES, 16'd1);
        write_register(CFG_REPEAT_SAMPLES, 16'd2);
        cfg_valid <= 1'b0;

        // The calibration set has both extremes as outliers and a symmetric middle,
        // so the averaged baseline lands exactly on the centre value.
        centre     = $urandom_range(400, 45000);
        spread_in  = $urandom_range(1, 100);
        spread_out = spread_in + $urandom_range(1, 200);
        cal_set[0] = '0;
        cal_set[1] = 16'hFFFF;
        cal_set[2] = sample_t'(centre - spread_out);
        cal_set[3] = sample_t'(centre + spread_out);
        cal_set[4] = sample_t'(centre - spread_in);
        cal_set[5] = sample_t'(centre + spread_in);
        for (k = 6; k < CAL_COUNT; k++) begin
            cal_set[k] = sample_t'(centre);
        end
        for (k = CAL_COUNT - 1; k > 0; k--) begin
            left = $urandom_range(0, k);
            swap = cal_set[k];
            cal_set[k] = cal_set[left];
            cal_set[left] = swap;
        end
        for (k = 0; k < CAL_COUNT; k++) begin
            send_sample(cal_set[k], 1'($urandom_range(0, 1)));
        end

        // A peak exactly on the threshold is a release, one above it counts.
        send_sample(sample_t'(centre + 80), 1'b0);
        send_sample(sample_t'(centre + 81), 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(sample_t'(centre + 81), 1'b1);
        send_sample(16'h0000, 1'b1);
        send_sample(sample_t'(centre + 200), 1'b1);
        send_sample(16'h0001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(sample_t'(centre + 80), 1'b0);
        drain_results();

        touching     = 1'b0;
        episode_mode = 1'b0;
        left         = 0;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    pick_margin = FIELD_W'(GATE_MARGIN_RST);
                    pick_single = GROUP_W'(SINGLE_SAMPLES_RST);
                    pick_repeat = GROUP_W'(REPEAT_SAMPLES_RST);
                end
                1: begin
                    pick_margin = '0;
                    pick_single = 4'd1;
                    pick_repeat = 4'd15;
                end
                2: begin
                    pick_margin = 16'hFFFF;
                    pick_single = 4'd15;
                    pick_repeat = 4'd1;
                end
                3: begin
                    pick_margin = FIELD_W'($urandom_range(1, 400));
                    pick_single = 4'd0;
                    pick_repeat = 4'd0;
                end
                default: begin
                    pick_margin = FIELD_W'($urandom_range(0, 600));
                    pick_single = GROUP_W'($urandom_range(1, 15));
                    pick_repeat = GROUP_W'($urandom_range(1, 15));
                end
            endcase
            write_register(CFG_GATE_MARGIN, pick_margin);
            write_register(CFG_SINGLE_SAMPLES, {12'd0, pick_single});
            write_register(CFG_REPEAT_SAMPLES, {12'd0, pick_repeat});
            if (p == 5) begin
                write_register(CFG_SPARE, FIELD_W'($urandom_range(0, 65535)));
            end
            cfg_valid <= 1'b0;
            steady = (p == 6);
            threshold = centre + pick_margin;

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 4 && n == 40) begin
                    stall_asks++;
                end
                // Touches and releases come in episodes of random length.
                if (left == 0) begin
                    touching     = ~touching;
                    left         = $urandom_range(2, 30);
                    episode_mode = 1'($urandom_range(0, 1));
                end
                left--;
                mode = ($urandom_range(0, 9) == 0) ? ~episode_mode : episode_mode;
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    charge = sample_t'($urandom_range(0, 65535));
                end else if (roll < 13) begin
                    charge = (threshold > 65535) ? 16'hFFFF : sample_t'(threshold);
                end else if (touching && threshold < 65535) begin
                    roll = threshold + $urandom_range(1, 2000);
                    charge = (roll > 65535) ? 16'hFFFF : sample_t'(roll);
                end else begin
                    floor_val = (centre > 300) ? centre - 300 : 0;
                    roll = $urandom_range(floor_val, (threshold > 65535) ? 65535 : threshold);
                    charge = sample_t'(roll);
                end
                send_sample(charge, mode);
            end
            drain_results();
        end
        steady = 1'b0;

        $display("Run summary: %0d samples under %0d register settings, calibration centre %0d.",
                 inputs_seen, PHASES + 1, centre);
        $display("Scan rounds reported: %0d, of which presses: %0d.", rounds_seen, presses_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ capacitive_touch_key_detector_core.f @@
hw/rtl/ctkd_pkg.sv
hw/rtl/ctkd_sort_cell.sv
hw/rtl/ctkd_avg_div.sv
hw/rtl/capacitive_touch_key_detector_core.sv
bench/touch_key_checker.sv
bench/tb.sv
